// ===== hdl/aes_pkg.sv =====
// AES-128 package: S-box tables, GF(2^8) helpers and round transforms.
// Used by the key expansion unit, the round unit and the top level.
`default_nettype none
package aes_pkg;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned BlockW    = 128;
    localparam int unsigned HalfW     = 64;
    localparam int unsigned RoundW    = 4;

    typedef enum logic [0:0] {
        KIND_ENCRYPT = 1'b0,
        KIND_DECRYPT = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic             last;
        kind_t            kind;
    } round_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1B;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Byte i of the block sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int i);
        return s[BlockW-1-8*i -: 8];
    endfunction

    function automatic logic [BlockW-1:0] shift_rows(input logic [BlockW-1:0] s,
                                                     input logic inverse);
        logic [BlockW-1:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inverse) begin
                    t[BlockW-1-8*(r+4*((c+r)%4)) -: 8] = get_byte(s, r+4*c);
                end else begin
                    t[BlockW-1-8*(r+4*c) -: 8] = get_byte(s, r+4*((c+r)%4));
                end
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inverse);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] o;
        for (int j = 0; j < 4; j++) begin
            a[j]  = col[31-8*j -: 8];
            x2[j] = xtime(a[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
            m2[j] = x2[j];
            m3[j] = x2[j] ^ a[j];
            m9[j] = x8[j] ^ a[j];
            mb[j] = x8[j] ^ x2[j] ^ a[j];
            md[j] = x8[j] ^ x4[j] ^ a[j];
            me[j] = x8[j] ^ x4[j] ^ x2[j];
        end
        for (int r = 0; r < 4; r++) begin
            if (inverse) begin
                o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
            end else begin
                o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        return o;
    endfunction

    function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s,
                                                      input logic inverse);
        logic [BlockW-1:0] t;
        for (int c = 0; c < 4; c++) begin
            t[BlockW-1-32*c -: 32] = mix_col(s[BlockW-1-32*c -: 32], inverse);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_key_exp.sv =====
// AES-128 key expansion: one round key per cycle into the round-key memory.
// Depends on aes_pkg. Read port is registered and addressed by round number.
`default_nettype none
module aes_key_exp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [aes_pkg::BlockW-1:0]     key,
    input  wire logic [aes_pkg::RoundW-1:0]     rd_round,
    output logic      [aes_pkg::BlockW-1:0]     rd_key,
    output logic                                busy
);
    import aes_pkg::*;

    logic [HalfW-1:0]  store_hi [NumRounds+1];
    logic [HalfW-1:0]  store_lo [NumRounds+1];
    logic [BlockW-1:0] cur_reg;
    logic [RoundW-1:0] cnt_reg;
    logic              busy_reg;
    logic [BlockW-1:0] wr_data;
    logic [BlockW-1:0] nxt_key;
    logic [RoundW-1:0] rc_idx;
    logic [31:0]       w0, w1, w2, w3, t;

    always_comb begin
        wr_data = start ? key : cur_reg;
        rc_idx  = start ? 4'd1 : (cnt_reg + 4'd1);
        w0 = wr_data[127:96];
        w1 = wr_data[95:64];
        w2 = wr_data[63:32];
        w3 = wr_data[31:0];
        t  = {sbox(w3[23:16]) ^ rcon(rc_idx), sbox(w3[15:8]),
              sbox(w3[7:0]), sbox(w3[31:24])};
        nxt_key[127:96] = w0 ^ t;
        nxt_key[95:64]  = w1 ^ w0 ^ t;
        nxt_key[63:32]  = w2 ^ w1 ^ w0 ^ t;
        nxt_key[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd1;
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg + 4'd1;
            busy_reg <= (cnt_reg != RoundW'(NumRounds));
        end
    end

    logic [RoundW-1:0] wr_idx;
    assign wr_idx = start ? '0 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (start || busy_reg) begin
            store_hi[wr_idx] <= wr_data[127:64];
            store_lo[wr_idx] <= wr_data[63:0];
            cur_reg          <= nxt_key;
        end
        rd_key <= {store_hi[rd_round], store_lo[rd_round]};
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

// ===== hdl/aes_round.sv =====
// AES round unit: one encrypt or decrypt round per cycle on the state register, while step is high.
// Depends on aes_pkg; round key comes from the key expansion memory.
`default_nettype none
module aes_round (
    input  wire logic                         aclk,
    input  wire aes_pkg::round_ctrl_t         ctrl,
    input  wire logic                         step,
    input  wire logic [aes_pkg::BlockW-1:0]   din,
    input  wire logic [aes_pkg::BlockW-1:0]   rkey,
    output logic      [aes_pkg::BlockW-1:0]   state
);
    import aes_pkg::*;

    logic [BlockW-1:0] state_reg;
    logic [BlockW-1:0] state_next;
    logic [BlockW-1:0] sb, sr, mc, ak;

    always_comb begin
        if (ctrl.kind == KIND_ENCRYPT) begin
            for (int i = 0; i < 16; i++) begin
                sb[BlockW-1-8*i -: 8] = sbox(state_reg[BlockW-1-8*i -: 8]);
            end
            sr = shift_rows(sb, 1'b0);
            mc = ctrl.last ? sr : mix_columns(sr, 1'b0);
            ak = mc ^ rkey;
            state_next = ctrl.start ? (din ^ rkey) : ak;
        end else begin
            // Decrypt step: inverse shift, inverse sub, key add, then inverse mix
            // except on the last step.
            sr = shift_rows(state_reg, 1'b1);
            for (int i = 0; i < 16; i++) begin
                sb[BlockW-1-8*i -: 8] = inv_sbox(sr[BlockW-1-8*i -: 8]);
            end
            ak = sb ^ rkey;
            mc = ctrl.last ? ak : mix_columns(ak, 1'b1);
            state_next = ctrl.start ? (din ^ rkey) : mc;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;
endmodule
`default_nettype wire

// ===== hdl/aes128_block_cipher_top.sv =====
// AES-128 encrypt/decrypt core, top level with sequencer and handshakes.
// Encrypt and decrypt both run the same step sequence from acceptance to result valid.
// One block at a time: a new block is accepted only after the previous result is taken.
// Throughput is set by the single shared round unit, one round per cycle.
// A key register write starts a round-key expansion; reset clears control state.
// Depends on aes_pkg, aes_key_exp and aes_round.
`default_nettype none
module aes128_block_cipher_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [63:0] s_block_high,
    input  wire logic [63:0] s_block_low,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_high,
    output logic [63:0]      m_result_low
);
    import aes_pkg::*;

    logic [HalfW-1:0]  key_high_reg;
    logic [HalfW-1:0]  key_low_reg;
    logic              kstart_reg;
    logic              kbusy;
    logic [BlockW-1:0] rkey;
    state_t            state_reg, state_next;
    kind_t             kind_reg;
    logic [RoundW-1:0] cnt_reg, cnt_next;
    logic [RoundW-1:0] rd_round;
    logic [BlockW-1:0] din_reg;
    logic [BlockW-1:0] state_q;
    logic              step;
    round_ctrl_t       ctrl;
    logic              first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            kstart_reg   <= 1'b0;
        end else begin
            kstart_reg <= cfg_we;
            if (cfg_we) begin
                if (cfg_index == CFG_KEY_HIGH) begin
                    key_high_reg <= cfg_data;
                end else begin
                    key_low_reg <= cfg_data;
                end
            end
        end
    end

    aes_key_exp u_key_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (kstart_reg),
        .key      ({key_high_reg, key_low_reg}),
        .rd_round (rd_round),
        .rd_key   (rkey),
        .busy     (kbusy)
    );

    // Round count: encrypt reads keys 0..10, decrypt reads 10 down to 0.
    // The key read is issued from cnt_next, in the cycle before its use.
    assign rd_round = (kind_reg == KIND_ENCRYPT) ? cnt_next : RoundW'(NumRounds) - cnt_next;

    assign s_ready = (state_reg == ST_IDLE) && !kbusy && !kstart_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid && s_ready) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!first_reg) begin
                    step = 1'b1;
                    if (cnt_reg == RoundW'(NumRounds)) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            first_reg <= (state_reg == ST_IDLE) && s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= kind_t'(s_kind);
            din_reg  <= {s_block_high, s_block_low};
        end
    end

    // Encrypt: step 0 loads din^k0, steps 1..10 are rounds.
    // Decrypt: step 0 loads din^k10, each later step undoes one round and adds
    // the next lower key; the last step skips the inverse mix.
    always_comb begin
        ctrl.kind  = kind_reg;
        ctrl.start = (cnt_reg == '0);
        ctrl.last  = (cnt_reg == RoundW'(NumRounds));
    end

    aes_round u_round (
        .aclk  (aclk),
        .ctrl  (ctrl),
        .step  (step),
        .din   (din_reg),
        .rkey  (rkey),
        .state (state_q)
    );

    assign m_valid       = (state_reg == ST_DONE);
    assign m_result_high = state_q[127:64];
    assign m_result_low  = state_q[63:0];
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the AES-128 encrypt/decrypt core, ECB, one block per transaction.
// A small scoreboard class predicts every block from its own key schedule and cipher.
// Depends on aes_pkg and aes128_block_cipher_top.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import aes_pkg::*;

    typedef logic [7:0] block_bytes_t [16];

    class cipher_scoreboard;
        logic [7:0] fwd_box [256];
        logic [7:0] inv_box [256];
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        block_bytes_t round_keys [11];
        logic [127:0] expected_blocks [$];
        int unsigned errors;

        function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] m);
            logic [7:0] r;
            r = 8'h00;
            while (m != 0) begin
                if (m[0]) r ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
                m = m >> 1;
            end
            return r;
        endfunction

        function new();
            logic [7:0] b;
            logic [7:0] s;
            for (int a = 0; a < 256; a++) begin
                b = 8'h00;
                for (int c = 1; c < 256; c++) begin
                    if (gf_mul(a[7:0], c[7:0]) == 8'h01) b = c[7:0];
                end
                s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                    ^ {b[3:0], b[7:4]} ^ 8'h63;
                fwd_box[a] = s;
                inv_box[s] = a[7:0];
            end
            key_hi = '0;
            key_lo = '0;
            errors = 0;
            expand_key();
        endfunction

        function void expand_key();
            logic [7:0] w [44][4];
            logic [7:0] t [4];
            logic [7:0] rc;
            logic [127:0] k;
            k = {key_hi, key_lo};
            rc = 8'h01;
            for (int i = 0; i < 16; i++) w[i/4][i%4] = k[127-8*i -: 8];
            for (int i = 4; i < 44; i++) begin
                t = w[i-1];
                if (i % 4 == 0) begin
                    t[0] = fwd_box[w[i-1][1]] ^ rc;
                    t[1] = fwd_box[w[i-1][2]];
                    t[2] = fwd_box[w[i-1][3]];
                    t[3] = fwd_box[w[i-1][0]];
                    rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1B : 8'h00);
                end
                for (int j = 0; j < 4; j++) w[i][j] = w[i-4][j] ^ t[j];
            end
            for (int r = 0; r < 11; r++) begin
                for (int i = 0; i < 16; i++) round_keys[r][i] = w[4*r + i/4][i%4];
            end
        endfunction

        function void write_key(cfg_index_t idx, logic [63:0] value);
            if (idx == CFG_KEY_HIGH) key_hi = value;
            else key_lo = value;
            expand_key();
        endfunction

        function logic [127:0] transform(kind_t kind, logic [127:0] blk);
            block_bytes_t s;
            block_bytes_t t;
            logic [7:0] col [4];
            logic [7:0] coef [4];
            logic [127:0] out;
            for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
            if (kind == KIND_ENCRYPT) coef = '{8'h02, 8'h03, 8'h01, 8'h01};
            else coef = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
            if (kind == KIND_ENCRYPT) begin
                for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][i];
            end
            for (int n = 1; n <= 10; n++) begin
                int rd;
                rd = (kind == KIND_ENCRYPT) ? n : 11 - n;
                if (kind == KIND_ENCRYPT) begin
                    for (int i = 0; i < 16; i++) s[i] = fwd_box[s[i]];
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++) t[r+4*c] = s[r+4*((c+r)%4)];
                    s = t;
                end else begin
                    for (int i = 0; i < 16; i++) s[i] ^= round_keys[rd][i];
                end
                if (rd != 10) begin
                    for (int c = 0; c < 4; c++) begin
                        for (int j = 0; j < 4; j++) col[j] = s[4*c+j];
                        for (int r = 0; r < 4; r++) begin
                            s[4*c+r] = 8'h00;
                            for (int j = 0; j < 4; j++)
                                s[4*c+r] ^= gf_mul(col[j], coef[(j-r+4)%4]);
                        end
                    end
                end
                if (kind == KIND_ENCRYPT) begin
                    for (int i = 0; i < 16; i++) s[i] ^= round_keys[rd][i];
                end else begin
                    for (int r = 0; r < 4; r++)
                        for (int c = 0; c < 4; c++) t[r+4*((c+r)%4)] = s[r+4*c];
                    for (int i = 0; i < 16; i++) s[i] = inv_box[t[i]];
                end
            end
            if (kind == KIND_DECRYPT) begin
                for (int i = 0; i < 16; i++) s[i] ^= round_keys[0][i];
            end
            for (int i = 0; i < 16; i++) out[127-8*i -: 8] = s[i];
            return out;
        endfunction

        function void note_block(kind_t kind, logic [63:0] hi, logic [63:0] lo);
            logic [127:0] exp_blk;
            exp_blk = transform(kind, {hi, lo});
            expected_blocks = {expected_blocks, exp_blk};
        endfunction

        function void check_result(logic [63:0] hi, logic [63:0] lo);
            logic [127:0] exp_blk;
            if (expected_blocks.size() == 0) begin
                $error("result_high/result_low: unexpected transaction %h %h", hi, lo);
                errors++;
                return;
            end
            exp_blk = expected_blocks.pop_front();
            if (hi !== exp_blk[127:64]) begin
                $error("result_high: expected %h, actual %h", exp_blk[127:64], hi);
                errors++;
            end
            if (lo !== exp_blk[63:0]) begin
                $error("result_low: expected %h, actual %h", exp_blk[63:0], lo);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = CFG_KEY_HIGH;
    logic [63:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = KIND_ENCRYPT;
    logic [63:0] s_block_high = '0;
    logic [63:0] s_block_low = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;

    cipher_scoreboard sb;
    bit gaps_on = 1'b1;
    int unsigned results_seen = 0;

    aes128_block_cipher_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_block_high(s_block_high), .s_block_low(s_block_low),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_high(m_result_high), .m_result_low(m_result_low)
    );

    always #6 aclk = ~aclk;

    task automatic load_key(logic [63:0] hi, logic [63:0] lo);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_KEY_HIGH;
        cfg_data <= hi;
        sb.write_key(CFG_KEY_HIGH, hi);
        @(posedge aclk);
        cfg_index <= CFG_KEY_LOW;
        cfg_data <= lo;
        sb.write_key(CFG_KEY_LOW, lo);
        @(posedge aclk);
        cfg_we <= 1'b0;
        // Let the round-key expansion finish before the next block.
        repeat (16) @(posedge aclk);
    endtask

    task automatic send_block(kind_t kind, logic [63:0] hi, logic [63:0] lo);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_block_high <= hi;
        s_block_low <= lo;
        do @(posedge aclk); while (!s_ready);
        sb.note_block(kind, hi, lo);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_blocks.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        int unsigned stall;
        wait (aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, 19) : 0;
            if (results_seen == 150) stall = 400;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result(m_result_high, m_result_low);
            results_seen++;
        end
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [63:0] keys_hi [6];
        logic [63:0] keys_lo [6];
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        keys_hi = '{64'h0001020304050607, 64'h0, 64'hFFFFFFFFFFFFFFFF,
                    64'h2B7E151628AED2A6, 64'hAAAAAAAAAAAAAAAA, {$urandom(), $urandom()}};
        keys_lo = '{64'h08090A0B0C0D0E0F, 64'h0, 64'hFFFFFFFFFFFFFFFF,
                    64'hABF7158809CF4F3C, 64'h5555555555555555, {$urandom(), $urandom()}};
        load_key(keys_hi[0], keys_lo[0]);
        send_block(KIND_ENCRYPT, 64'h0011223344556677, 64'h8899AABBCCDDEEFF);
        send_block(KIND_DECRYPT, 64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A);
        send_block(KIND_ENCRYPT, 64'h0, 64'h0);
        send_block(KIND_DECRYPT, 64'h0, 64'h0);
        send_block(KIND_ENCRYPT, '1, '1);
        send_block(KIND_DECRYPT, '1, '1);
        send_block(KIND_ENCRYPT, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
        send_block(KIND_DECRYPT, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
        send_block(KIND_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
        drain();
        // Only the high key half is written: the blocks that follow use it with the previous low half.
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_KEY_HIGH;
        cfg_data <= 64'hFFFFFFFFFFFFFFFF;
        sb.write_key(CFG_KEY_HIGH, 64'hFFFFFFFFFFFFFFFF);
        @(posedge aclk);
        cfg_we <= 1'b0;
        repeat (16) @(posedge aclk);
        send_block(KIND_ENCRYPT, 64'h3243F6A8885A308D, 64'h313198A2E0370734);
        send_block(KIND_DECRYPT, 64'h3243F6A8885A308D, 64'h313198A2E0370734);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            load_key(keys_hi[ph], keys_lo[ph]);
            gaps_on = (ph != 2);
            for (int n = 0; n < 280; n++) begin
                send_block($urandom_range(0, 1) ? KIND_DECRYPT : KIND_ENCRYPT,
                           rand64(), rand64());
                if (n == 140) drain();
            end
            drain();
        end
        gaps_on = 1'b1;
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_blocks.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
